@@ src/max_subarray_sum_mod_parity_defines.svh @@
// Assertion macros used by the checker file of this block.
`ifndef MAX_SUBARRAY_SUM_MOD_PARITY_DEFINES_SVH
`define MAX_SUBARRAY_SUM_MOD_PARITY_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MSSMP_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MSSMP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ src/mssmp_pkg.sv @@
// Types and constants of the odd divisor-multiple run sum block.
package mssmp_pkg;

  localparam int VALUE_WIDTH   = 16;
  localparam int SUM_WIDTH     = 48;
  localparam int DIVISOR_WIDTH = 8;

  localparam logic [DIVISOR_WIDTH-1:0] DIVISOR_RESET = 8'd93;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;
  } item_t;

  typedef struct packed {
    logic [SUM_WIDTH-1:0] best_sum;
    logic                 found;
    logic                 overflow;
  } result_t;

endpackage

@@ src/mssmp_front.sv @@
// Front end: accepts items, keeps the saturating prefix sum and its serial remainder.
module mssmp_front import mssmp_pkg::*; #(
  parameter int MAX_DIVISOR = 128,
  localparam int REM_WIDTH = $clog2(MAX_DIVISOR),
  localparam int ENTRY_WIDTH = SUM_WIDTH + REM_WIDTH + 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [DIVISOR_WIDTH-1:0] divisor,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  item_t                    item,
  output logic                     push_valid,
  input  logic                     push_ready,
  output logic [ENTRY_WIDTH-1:0]   push_data
);

  localparam int XW = ((REM_WIDTH > VALUE_WIDTH) ? REM_WIDTH : VALUE_WIDTH) + 1;
  localparam int CW = $clog2(XW + 1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]           state;
  logic [SUM_WIDTH-1:0] prefix_sum;
  logic [REM_WIDTH-1:0] prefix_rem;
  logic                 saturated;
  logic                 last_q;
  logic [REM_WIDTH:0]   dvs;
  logic [XW-1:0]        dividend;
  logic [REM_WIDTH-1:0] part;
  logic [CW-1:0]        cnt;

  logic                 accept;
  logic [SUM_WIDTH:0]   sum_ext;
  logic [REM_WIDTH:0]   eff_div;
  logic [REM_WIDTH:0]   trial;
  logic [REM_WIDTH:0]   diff;
  logic [REM_WIDTH-1:0] part_next;

  assign item_stall = rst || (state != F_IDLE);
  assign accept     = item_valid && !item_stall;
  assign push_valid = (state == F_PUSH);
  assign push_data  = {prefix_sum, part, last_q, saturated};

  assign sum_ext = {1'b0, prefix_sum}
                 + {{(SUM_WIDTH + 1 - VALUE_WIDTH){1'b0}}, item.value};

  // Divisor zero acts as one; clamp anything above the table size.
  always_comb begin
    if (divisor == '0) begin
      eff_div = (REM_WIDTH + 1)'(1);
    end else if (int'(divisor) > MAX_DIVISOR) begin
      eff_div = (REM_WIDTH + 1)'(MAX_DIVISOR);
    end else begin
      eff_div = (REM_WIDTH + 1)'(divisor);
    end
  end

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign trial     = {part, dividend[XW-1]};
  assign diff      = trial - dvs;
  assign part_next = (trial >= dvs) ? diff[REM_WIDTH-1:0] : trial[REM_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      prefix_sum <= '0;
      prefix_rem <= '0;
      saturated  <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (sum_ext[SUM_WIDTH]) begin
              prefix_sum <= '1;
              saturated  <= 1'b1;
            end else begin
              prefix_sum <= sum_ext[SUM_WIDTH-1:0];
            end
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (cnt == CW'(1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            // Drop the stream state after the last item of a sequence.
            if (last_q) begin
              prefix_sum <= '0;
              prefix_rem <= '0;
              saturated  <= 1'b0;
            end else begin
              prefix_rem <= part;
            end
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && accept) begin
      last_q   <= item.last;
      dvs      <= eff_div;
      dividend <= XW'(prefix_rem) + XW'(item.value);
      part     <= '0;
      cnt      <= CW'(XW);
    end else if (state == F_DIV) begin
      part     <= part_next;
      dividend <= {dividend[XW-2:0], 1'b0};
      cnt      <= cnt - CW'(1);
    end
  end

endmodule

@@ src/mssmp_queue.sv @@
// Short queue of prefix entries between the front and back ends.
module mssmp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNTW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

@@ src/mssmp_back.sv @@
// Back end: minimum prefix table lookup, best run update and result register.
module mssmp_back import mssmp_pkg::*; #(
  parameter int MAX_DIVISOR = 128,
  localparam int REM_WIDTH = $clog2(MAX_DIVISOR),
  localparam int ENTRY_WIDTH = SUM_WIDTH + REM_WIDTH + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  logic [ENTRY_WIDTH-1:0] pop_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result
);

  localparam int TD = 2 * MAX_DIVISOR;
  localparam int AW = $clog2(TD);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_CAND = 2'd1;
  localparam logic [1:0] B_UPD  = 2'd2;

  logic [SUM_WIDTH-1:0] min_mem [TD];
  logic [TD-1:0]        entry_valid;

  logic [1:0]           state;
  logic [SUM_WIDTH-1:0] best_run;
  logic                 best_valid;

  logic [SUM_WIDTH-1:0] h_sum;
  logic [REM_WIDTH-1:0] h_rem;
  logic                 h_last;
  logic                 h_sat;
  logic [AW-1:0]        own_addr;
  logic [AW-1:0]        opp_addr;
  logic                 take;

  logic [SUM_WIDTH-1:0] cur_sum;
  logic                 cur_last;
  logic                 cur_sat;
  logic [AW-1:0]        own_addr_q;
  logic                 own_v_q;
  logic                 own_z_q;
  logic                 opp_v_q;
  logic                 opp_z_q;
  logic [SUM_WIDTH-1:0] rd_own;
  logic [SUM_WIDTH-1:0] rd_opp;

  logic [SUM_WIDTH-1:0] own_val;
  logic [SUM_WIDTH-1:0] opp_val;
  logic                 opp_ok;
  logic                 wr_need;
  logic [SUM_WIDTH-1:0] cand_q;
  logic                 opp_ok_q;
  logic                 wr_need_q;

  logic                 upd_best;
  logic [SUM_WIDTH-1:0] best_run_next;
  logic                 best_valid_next;
  logic                 advance;
  logic                 wr_en;

  assign {h_sum, h_rem, h_last, h_sat} = pop_data;

  assign own_addr = h_sum[0] ? AW'(MAX_DIVISOR) + AW'(h_rem) : AW'(h_rem);
  assign opp_addr = h_sum[0] ? AW'(h_rem) : AW'(MAX_DIVISOR) + AW'(h_rem);

  assign pop_ready = (state == B_IDLE);
  assign take      = pop_valid && pop_ready;

  // Even parity, remainder zero holds the empty prefix until first written.
  assign own_val = own_v_q ? rd_own : '0;
  assign opp_val = opp_v_q ? rd_opp : '0;
  assign opp_ok  = (opp_v_q || opp_z_q) && (opp_val <= cur_sum);
  assign wr_need = !(own_v_q || own_z_q) || (cur_sum < own_val);

  assign upd_best        = opp_ok_q && (!best_valid || (cand_q > best_run));
  assign best_run_next   = upd_best ? cand_q : best_run;
  assign best_valid_next = best_valid || upd_best;

  assign advance = !cur_last || !result_valid || !result_stall;
  assign wr_en   = (state == B_UPD) && advance && wr_need_q;

  always_ff @(posedge clk) begin
    if (take) begin
      rd_own <= min_mem[own_addr];
      rd_opp <= min_mem[opp_addr];
    end
    if (wr_en) begin
      min_mem[own_addr_q] <= cur_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_sum    <= h_sum;
      cur_last   <= h_last;
      cur_sat    <= h_sat;
      own_addr_q <= own_addr;
      own_v_q    <= entry_valid[own_addr];
      own_z_q    <= (own_addr == '0);
      opp_v_q    <= entry_valid[opp_addr];
      opp_z_q    <= (opp_addr == '0);
    end
    if (state == B_CAND) begin
      cand_q    <= cur_sum - opp_val;
      opp_ok_q  <= opp_ok;
      wr_need_q <= wr_need;
    end
    if (state == B_UPD && advance) begin
      best_run <= best_run_next;
      if (cur_last) begin
        result.best_sum <= best_valid_next ? best_run_next : '0;
        result.found    <= best_valid_next;
        result.overflow <= cur_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      entry_valid  <= '0;
      best_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // Load a new result, or drop the held one once it is taken.
      if (state == B_UPD && advance && cur_last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (take) begin
            state <= B_CAND;
          end
        end
        B_CAND: begin
          state <= B_UPD;
        end
        B_UPD: begin
          if (advance) begin
            if (cur_last) begin
              // Emit and clear the sequence state.
              entry_valid  <= '0;
              best_valid   <= 1'b0;
            end else begin
              best_valid <= best_valid_next;
              if (wr_need_q) begin
                entry_valid[own_addr_q] <= 1'b1;
              end
            end
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/max_subarray_sum_mod_parity.sv @@
// The front end takes one item at a time through its serial remainder loop: an accept,
//   VALUE_WIDTH + 1 restoring steps, then a queue push that waits for queue space.
// The back end works on one item at a time through table read, compare and write.
// Reset: synchronous; divisor returns to 93, all sequence state clears at
//   once through the table valid bits, so no clearing pass is needed.
module max_subarray_sum_mod_parity import mssmp_pkg::*; #(
  parameter int MAX_DIVISOR = 128
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [DIVISOR_WIDTH-1:0] cfg_data,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  item_t                    item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output result_t                  result
);

  // Each queue entry carries the prefix sum, its remainder, the last mark and
  // the sticky saturation flag of the sequence so far.
  localparam int REM_WIDTH   = $clog2(MAX_DIVISOR);
  localparam int ENTRY_WIDTH = SUM_WIDTH + REM_WIDTH + 2;
  localparam int QUEUE_DEPTH = 2;

  logic [DIVISOR_WIDTH-1:0] divisor;
  logic                     push_valid;
  logic                     push_ready;
  logic [ENTRY_WIDTH-1:0]   push_data;
  logic                     pop_valid;
  logic                     pop_ready;
  logic [ENTRY_WIDTH-1:0]   pop_data;

  // Users must write only while the block is idle (unenforced); ready out of reset.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= DIVISOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      divisor <= cfg_data;
    end
  end

  // Front end: prefix sum and remainder by the divisor, one item at a time.
  mssmp_front #(
    .MAX_DIVISOR (MAX_DIVISOR)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .divisor    (divisor),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple the two ends so a stalled result does not hold up the divider.
  mssmp_queue #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: match against the opposite parity entry, keep the best odd run,
  // hold the result in its output register until taken.
  mssmp_back #(
    .MAX_DIVISOR (MAX_DIVISOR)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ src/mssmp_checker.sv @@
// Port-level checker of the run sum block and its bind to the top level.
`include "max_subarray_sum_mod_parity_defines.svh"

module mssmp_checker import mssmp_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  `MSSMP_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")
  `MSSMP_ASSERT_NOW(a_none_is_zero, clk, rst, result_valid, result.found || (result.best_sum == '0), "no run found but sum not zero")
  `MSSMP_ASSERT_NOW(a_found_is_odd, clk, rst, result_valid && result.found, result.best_sum[0], "best run sum is even")
  `MSSMP_ASSERT_NEXT(a_one_at_a_time, clk, rst, item_valid && !item_stall, item_stall, "item taken while divider busy")

endmodule

bind max_subarray_sum_mod_parity mssmp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

@@ sim/tb_max_subarray_sum_mod_parity.sv @@
`timescale 1ns / 100ps
// Testbench for the odd divisor-multiple maximum run sum block.
module tb_max_subarray_sum_mod_parity;
  import mssmp_pkg::*;

  localparam int MAX_DIVISOR = 128;
  // Cycles to let pass after the last result before touching the divisor:
  // covers an item still in the serial remainder loop plus the table update.
  localparam int SETTLE_CYCLES = 64;
  // Cycles with no item, result or register write before the run is aborted.
  // Longest legal quiet stretch is the output hold-off of the pressure test.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [DIVISOR_WIDTH-1:0] cfg_data = '0;
  logic                     item_valid = 1'b0;
  logic                     item_stall;
  item_t                    item = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  result_t                  result;

  max_subarray_sum_mod_parity #(
    .MAX_DIVISOR(MAX_DIVISOR)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction: running prefix sum, its remainder, and the smallest prefix seen
  // for each (parity, remainder) slot. Odd parity slots sit at MAX_DIVISOR up.
  // ---------------------------------------------------------------------------
  logic [DIVISOR_WIDTH-1:0] divisor_reg;
  logic [SUM_WIDTH-1:0]     prefix_sum;
  int                       prefix_residue;
  logic [SUM_WIDTH-1:0]     min_prefix [2*MAX_DIVISOR];
  bit                       slot_seen  [2*MAX_DIVISOR];
  logic [SUM_WIDTH-1:0]     best_run;
  bit                       best_found;
  bit                       sum_saturated;

  // Results still owed by the block, oldest first.
  result_t expected_runs[$];

  int mismatches     = 0;
  int items_sent     = 0;
  int runs_checked   = 0;
  int divisor_writes = 0;

  // Idling controls shared by the stimulus and the output side.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_left  = 0;

  function automatic void clear_sequence();
    prefix_sum     = '0;
    prefix_residue = 0;
    for (int i = 0; i < 2*MAX_DIVISOR; i++) begin
      min_prefix[i] = '0;
      slot_seen[i]  = 1'b0;
    end
    // The empty prefix: even, remainder zero, sum zero.
    slot_seen[0]  = 1'b1;
    best_run      = '0;
    best_found    = 1'b0;
    sum_saturated = 1'b0;
  endfunction

  function automatic int effective_divisor();
    if (divisor_reg == 0) return 1;
    if (int'(divisor_reg) > MAX_DIVISOR) return MAX_DIVISOR;
    return int'(divisor_reg);
  endfunction

  // Advance the prefix state by one accepted item; queue a result on last.
  function automatic void track_prefix(input item_t it);
    logic [SUM_WIDTH:0]   wide_sum;
    logic [SUM_WIDTH-1:0] run_sum;
    int                   parity;
    int                   slot;
    int                   opposite;
    result_t              run;
    wide_sum = {1'b0, prefix_sum} + it.value;
    if (wide_sum[SUM_WIDTH]) begin
      // Stick at all ones and flag it; the remainder keeps following values.
      prefix_sum    = '1;
      sum_saturated = 1'b1;
    end else begin
      prefix_sum = wide_sum[SUM_WIDTH-1:0];
    end
    prefix_residue = (prefix_residue + int'(it.value)) % effective_divisor();
    parity   = int'(prefix_sum[0]);
    slot     = parity * MAX_DIVISOR + prefix_residue;
    opposite = (1 - parity) * MAX_DIVISOR + prefix_residue;
    if (slot_seen[opposite] && min_prefix[opposite] <= prefix_sum) begin
      run_sum = prefix_sum - min_prefix[opposite];
      if (!best_found || run_sum > best_run) begin
        best_run   = run_sum;
        best_found = 1'b1;
      end
    end
    if (!slot_seen[slot] || prefix_sum < min_prefix[slot]) begin
      min_prefix[slot] = prefix_sum;
      slot_seen[slot]  = 1'b1;
    end
    if (it.last) begin
      run.best_sum = best_found ? best_run : '0;
      run.found    = best_found;
      run.overflow = sum_saturated;
      expected_runs.push_back(run);
      clear_sequence();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0d, want %0d (result %0d, t=%0t)",
             field, got, want, runs_checked, $realtime);
    mismatches++;
  endtask

  task automatic check_run(input result_t got);
    result_t want;
    if (expected_runs.size() == 0) begin
      report_mismatch("unexpected result best_sum", 64'(got.best_sum), 64'(0));
      return;
    end
    want = expected_runs.pop_front();
    if (got.best_sum !== want.best_sum)
      report_mismatch("best_sum", 64'(got.best_sum), 64'(want.best_sum));
    if (got.found !== want.found)
      report_mismatch("found", 64'(got.found), 64'(want.found));
    if (got.overflow !== want.overflow)
      report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
    runs_checked++;
  endtask

  // Compare every result taken from the block against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      check_run(result);
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    int burst_left;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_stall <= 1'b0;
      end else if (hold_left > 0) begin
        // Hold off long enough for the block to back up into its input.
        hold_left--;
        result_stall <= 1'b1;
      end else if (!rx_idle_on) begin
        burst_left = 0;
        result_stall <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        result_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(1, 15) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: abort when nothing moves for too long.
  // ---------------------------------------------------------------------------
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d results still owed", expected_runs.size());
        $display("max_subarray_sum_mod_parity verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Offer one item, hold it until taken, then feed it to the predictor.
  task automatic send_item(input logic [VALUE_WIDTH-1:0] value, input bit last);
    item_t it;
    int    gap;
    it.value = value;
    it.last  = last;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    track_prefix(it);
    items_sent++;
  endtask

  // Drop valid, wait for every owed result, then let in-flight items finish.
  task automatic settle();
    item_valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [DIVISOR_WIDTH-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    divisor_reg = value;
    divisor_writes++;
  endtask

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    logic [VALUE_WIDTH-1:0] v;
    case ($urandom_range(0, 5))
      0, 1:    v = VALUE_WIDTH'($urandom());
      2, 3:    v = VALUE_WIDTH'($urandom_range(0, 15));
      4:       v = VALUE_WIDTH'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = '1;
          2:       v = VALUE_WIDTH'(1);
          default: v = 16'h8000;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_sequence(input int len);
    for (int i = 0; i < len; i++) begin
      send_item(pick_value(), i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Runs under the divisor left by reset: single odd multiple, zero, large values.
  task automatic test_reset_divisor();
    send_item(16'd93, 1'b1);
    send_item(16'd0, 1'b1);
    send_item(16'hFFFF, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'd31, 1'b1);
  endtask

  // Smallest and largest legal divisors, zero (acts as one), and above range.
  task automatic test_divisor_extremes();
    write_divisor(8'd2);
    // An odd multiple of two cannot exist: expect nothing found.
    send_item(16'd3, 1'b0);
    send_item(16'd5, 1'b0);
    send_item(16'd1, 1'b1);
    write_divisor(8'd128);
    send_item(16'd128, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd127, 1'b0);
    send_item(16'd128, 1'b1);
    write_divisor(8'd0);
    send_item(16'd4, 1'b0);
    send_item(16'd7, 1'b0);
    send_item(16'd2, 1'b1);
    write_divisor(8'd255);
    send_item(16'hFFFF, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b1);
    write_divisor(8'd1);
    send_item(16'd1, 1'b1);
  endtask

  // Change the divisor partway through a sequence; the table carries over.
  task automatic test_divisor_change_mid_sequence();
    write_divisor(8'd7);
    send_item(16'd10, 1'b0);
    send_item(16'd20, 1'b0);
    write_divisor(8'd5);
    send_item(16'd15, 1'b0);
    send_item(16'd4, 1'b1);
  endtask

  // Hold the output off while short sequences keep coming, so the block
  // backs up and stalls its input.
  task automatic test_output_backpressure();
    write_divisor(8'd3);
    hold_left = HOLD_OFF_CYCLES;
    for (int i = 0; i < 40; i++) begin
      send_sequence($urandom_range(1, 2));
    end
    settle();
  endtask

  // Random sequences over a spread of divisor settings, idling on both sides.
  task automatic test_random_phases();
    logic [DIVISOR_WIDTH-1:0] divisors[10];
    int                       start;
    divisors = '{8'd2, 8'd3, 8'd7, 8'd93, 8'd128, 8'd0, 8'd1, 8'd255, 8'd129, 8'd0};
    divisors[9] = DIVISOR_WIDTH'($urandom_range(0, 255));
    foreach (divisors[p]) begin
      write_divisor(divisors[p]);
      start = items_sent;
      while (items_sent - start < 100) begin
        send_sequence($urandom_range(1, 30));
      end
    end
  endtask

  // Final stretch at full rate: no gaps in the input, no stalls on the output.
  task automatic test_random_full_rate();
    int start;
    write_divisor(DIVISOR_WIDTH'($urandom_range(2, 128)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    start = items_sent;
    while (items_sent - start < 150) begin
      send_sequence($urandom_range(1, 20));
    end
    settle();
  endtask

  initial begin
    divisor_reg = DIVISOR_RESET;
    clear_sequence();
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_divisor();
    test_divisor_extremes();
    test_divisor_change_mid_sequence();
    test_output_backpressure();
    test_random_phases();
    test_random_full_rate();

    $display("covered %0d items in %0d checked sequences over %0d divisor writes",
             items_sent, runs_checked, divisor_writes);
    $display("incl. zero and above-range divisors, a mid-sequence divisor change, "
             , "a long output hold-off and a full-rate stretch");
    if (mismatches == 0) begin
      $display("max_subarray_sum_mod_parity verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("max_subarray_sum_mod_parity verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/mssmp_pkg.sv
src/mssmp_front.sv
src/mssmp_queue.sv
src/mssmp_back.sv
src/max_subarray_sum_mod_parity.sv
src/mssmp_checker.sv
sim/tb_max_subarray_sum_mod_parity.sv
